[rtl/tef_pkg.sv]
// Package for the tile engine register file: beat types, command and size
// codes, register offsets and field masks. No dependencies.
package tef_pkg;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  // access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // register offsets
  localparam logic [7:0] OFF_BGCNT0   = 8'h08;
  localparam logic [7:0] OFF_BGCNT2   = 8'h0C;
  localparam logic [7:0] OFF_WIN0H    = 8'h40;
  localparam logic [7:0] OFF_WIN1H    = 8'h42;
  localparam logic [7:0] OFF_WIN0V    = 8'h44;
  localparam logic [7:0] OFF_WIN1V    = 8'h46;
  localparam logic [7:0] OFF_WININ    = 8'h48;
  localparam logic [7:0] OFF_WINOUT   = 8'h4A;
  localparam logic [7:0] OFF_MOSAIC   = 8'h4C;
  localparam logic [7:0] OFF_BLDCNT   = 8'h50;
  localparam logic [7:0] OFF_BLDALPHA = 8'h52;
  localparam logic [7:0] OFF_BLDY     = 8'h54;

  // field masks, sized to the stored widths
  localparam logic [13:0] WIN_SEL_MASK     = 14'h3F3F;
  localparam logic [13:0] BLEND_CTRL_MASK  = 14'h3FFF;
  localparam logic [12:0] BLEND_ALPHA_MASK = 13'h1F1F;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  access_size;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic [8:0]  scanline;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        window0_active;
    logic        window1_active;
    logic [3:0]  ref_reload_pending;
  } out_beat_t;

endpackage

[rtl/tile_engine_register_file.sv]
// Tile engine register file: register decode, write merge, scanline window flags.
// Depends on tef_pkg.
//
// Result: an accepted beat has its result in the output register from the edge
//   that accepts it (out_valid high after that edge).
// Throughput: one beat per cycle; in_ready drops only while a result waits.
// Reset (rst_n low, synchronous): all registers zero, engine enabled, no result.
module tile_engine_register_file (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tef_pkg::in_beat_t in_beat,
  output logic              out_valid,
  input  logic              out_ready,
  output tef_pkg::out_beat_t out_beat,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import tef_pkg::*;

  // ---------------------------------------------------------------------------
  // Architectural registers
  // ---------------------------------------------------------------------------
  logic [15:0] bg_control_r [4];
  logic [15:0] bg_hscroll_r [4];
  logic [15:0] bg_vscroll_r [4];
  logic [15:0] affine_r     [8];
  logic [31:0] ref_point_r  [4];
  logic [3:0]  ref_reload_r;
  logic [15:0] window_horiz_r [2];
  logic [15:0] window_vert_r  [2];
  logic [13:0] win_inside_r;
  logic [13:0] win_outside_r;
  logic [15:0] mosaic_r;
  logic [13:0] blend_ctrl_r;
  logic [12:0] blend_alpha_r;
  logic [4:0]  brightness_r;
  logic [1:0]  window_y_r;
  logic        engine_enabled_r;

  logic [15:0] bg_control_nxt [4];
  logic [15:0] bg_hscroll_nxt [4];
  logic [15:0] bg_vscroll_nxt [4];
  logic [15:0] affine_nxt     [8];
  logic [31:0] ref_point_nxt  [4];
  logic [3:0]  ref_reload_nxt;
  logic [15:0] window_horiz_nxt [2];
  logic [15:0] window_vert_nxt  [2];
  logic [13:0] win_inside_nxt;
  logic [13:0] win_outside_nxt;
  logic [15:0] mosaic_nxt;
  logic [13:0] blend_ctrl_nxt;
  logic [12:0] blend_alpha_nxt;
  logic [4:0]  brightness_nxt;
  logic [1:0]  window_y_nxt;

  // output register
  logic      out_valid_r;
  out_beat_t out_beat_r;

  logic in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Read path. The scroll arrays are each read at one index, offset bits 3:2;
  // bg_control is read as a pair of entries selected by offset bit 2.
  // ---------------------------------------------------------------------------
  logic [7:0]  rd_off;
  logic [15:0] bgc_lo, bgc_hi, hs_sel, vs_sel;
  logic [15:0] rd_half;
  logic [31:0] rd_word;
  logic [31:0] rd_data;

  assign rd_off = in_beat.offset;
  assign bgc_lo = bg_control_r[{rd_off[2], 1'b0}];
  assign bgc_hi = bg_control_r[{rd_off[2], 1'b1}];
  assign hs_sel = bg_hscroll_r[rd_off[3:2]];
  assign vs_sel = bg_vscroll_r[rd_off[3:2]];

  always_comb begin
    rd_half = '0;
    if (rd_off[7:3] == 5'h01 && !rd_off[0]) begin
      rd_half = rd_off[1] ? bgc_hi : bgc_lo;
    end else if (rd_off[7:4] == 4'h1 && !rd_off[0]) begin
      rd_half = rd_off[1] ? vs_sel : hs_sel;
    end else begin
      case (rd_off)
        OFF_WIN0V:    rd_half = window_vert_r[0];
        OFF_WIN1V:    rd_half = window_vert_r[1];
        OFF_WININ:    rd_half = {2'b00, win_inside_r};
        OFF_WINOUT:   rd_half = {2'b00, win_outside_r};
        OFF_BLDCNT:   rd_half = {2'b00, blend_ctrl_r};
        OFF_BLDALPHA: rd_half = {3'b000, blend_alpha_r};
        default:      rd_half = '0;
      endcase
    end
  end

  // only a few offsets decode as words; the rest read zero
  always_comb begin
    rd_word = '0;
    if (rd_off == OFF_BGCNT0 || rd_off == OFF_BGCNT2) begin
      rd_word = {bgc_hi, bgc_lo};
    end else if (rd_off[7:4] == 4'h1 && rd_off[1:0] == 2'b00) begin
      rd_word = {vs_sel, hs_sel};
    end else if (rd_off == OFF_WININ) begin
      rd_word = {2'b00, win_outside_r, 2'b00, win_inside_r};
    end
  end

  always_comb begin
    rd_data = '0;
    if (in_beat.command == CMD_READ) begin
      case (in_beat.access_size)
        SIZE_HALF: rd_data = {16'h0000, rd_half};
        SIZE_WORD: rd_data = rd_word;
        default:   rd_data = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Write path. A word write is always two halfword writes (offset and
  // offset+2); the word-decoded registers land the same way through halves.
  // ---------------------------------------------------------------------------
  logic [7:0]  wr_off [2];
  logic [15:0] wr_dat [2];
  logic [1:0]  wr_en;
  logic [7:0]  wr_byte;
  logic        wr_active;

  assign wr_off[0] = in_beat.offset;
  assign wr_off[1] = in_beat.offset + 8'd2;
  assign wr_dat[0] = in_beat.write_data[15:0];
  assign wr_dat[1] = in_beat.write_data[31:16];
  assign wr_byte   = in_beat.write_data[7:0];
  assign wr_active = in_fire && in_beat.command == CMD_WRITE && engine_enabled_r;
  assign wr_en[0]  = in_beat.access_size == SIZE_HALF || in_beat.access_size == SIZE_WORD;
  assign wr_en[1]  = in_beat.access_size == SIZE_WORD;

  always_comb begin
    bg_control_nxt   = bg_control_r;
    bg_hscroll_nxt   = bg_hscroll_r;
    bg_vscroll_nxt   = bg_vscroll_r;
    affine_nxt       = affine_r;
    ref_point_nxt    = ref_point_r;
    ref_reload_nxt   = ref_reload_r;
    window_horiz_nxt = window_horiz_r;
    window_vert_nxt  = window_vert_r;
    win_inside_nxt   = win_inside_r;
    win_outside_nxt  = win_outside_r;
    mosaic_nxt       = mosaic_r;
    blend_ctrl_nxt   = blend_ctrl_r;
    blend_alpha_nxt  = blend_alpha_r;
    brightness_nxt   = brightness_r;
    window_y_nxt     = window_y_r;

    if (wr_active && in_beat.access_size == SIZE_BYTE) begin
      // byte merge: odd offset takes the high byte
      case ({wr_off[0][7:1], 1'b0})
        OFF_WIN0H, OFF_WIN1H: begin
          if (wr_off[0][0]) window_horiz_nxt[wr_off[0][1]][15:8] = wr_byte;
          else              window_horiz_nxt[wr_off[0][1]][7:0]  = wr_byte;
        end
        OFF_WIN0V, OFF_WIN1V: begin
          if (wr_off[0][0]) window_vert_nxt[wr_off[0][1]][15:8] = wr_byte;
          else              window_vert_nxt[wr_off[0][1]][7:0]  = wr_byte;
        end
        OFF_MOSAIC: begin
          if (wr_off[0][0]) mosaic_nxt[15:8] = wr_byte;
          else              mosaic_nxt[7:0]  = wr_byte;
        end
        default: ;
      endcase
    end else if (wr_active) begin
      for (int p = 0; p < 2; p++) begin
        if (wr_en[p]) begin
          if (wr_off[p][7:3] == 5'h01 && !wr_off[p][0]) begin
            bg_control_nxt[wr_off[p][2:1]] = wr_dat[p];
          end else if (wr_off[p][7:4] == 4'h1 && !wr_off[p][0]) begin
            if (wr_off[p][1]) bg_vscroll_nxt[wr_off[p][3:2]] = wr_dat[p];
            else              bg_hscroll_nxt[wr_off[p][3:2]] = wr_dat[p];
          end else if (wr_off[p][7:5] == 3'h1 && !wr_off[p][0]) begin
            // affine bank: bit 4 picks the bank, bit 3 coefficient vs reference
            if (!wr_off[p][3]) begin
              affine_nxt[{wr_off[p][4], wr_off[p][2:1]}] = wr_dat[p];
            end else begin
              if (wr_off[p][1])
                ref_point_nxt[{wr_off[p][4], wr_off[p][2]}][31:16] = wr_dat[p];
              else
                ref_point_nxt[{wr_off[p][4], wr_off[p][2]}][15:0] = wr_dat[p];
              ref_reload_nxt[{wr_off[p][4], wr_off[p][2]}] = 1'b1;
            end
          end else begin
            case (wr_off[p])
              OFF_WIN0H:    window_horiz_nxt[0] = wr_dat[p];
              OFF_WIN1H:    window_horiz_nxt[1] = wr_dat[p];
              OFF_WIN0V:    window_vert_nxt[0]  = wr_dat[p];
              OFF_WIN1V:    window_vert_nxt[1]  = wr_dat[p];
              OFF_WININ:    win_inside_nxt  = wr_dat[p][13:0] & WIN_SEL_MASK;
              OFF_WINOUT:   win_outside_nxt = wr_dat[p][13:0] & WIN_SEL_MASK;
              OFF_MOSAIC:   mosaic_nxt      = wr_dat[p];
              OFF_BLDCNT:   blend_ctrl_nxt  = wr_dat[p][13:0] & BLEND_CTRL_MASK;
              OFF_BLDALPHA: blend_alpha_nxt = wr_dat[p][12:0] & BLEND_ALPHA_MASK;
              OFF_BLDY:     brightness_nxt  = wr_dat[p][4:0];
              default: ;
            endcase
          end
        end
      end
    end

    // scanline start: set on start line, clear on end line (end wins)
    if (in_fire && in_beat.command == CMD_SCAN) begin
      for (int w = 0; w < 2; w++) begin
        if (in_beat.scanline[7:0] == window_vert_r[w][15:8]) window_y_nxt[w] = 1'b1;
        if (in_beat.scanline[7:0] == window_vert_r[w][7:0])  window_y_nxt[w] = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        bg_control_r[i] <= '0;
        bg_hscroll_r[i] <= '0;
        bg_vscroll_r[i] <= '0;
        ref_point_r[i]  <= '0;
      end
      for (int i = 0; i < 8; i++) affine_r[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        window_horiz_r[i] <= '0;
        window_vert_r[i]  <= '0;
      end
      ref_reload_r     <= '0;
      win_inside_r     <= '0;
      win_outside_r    <= '0;
      mosaic_r         <= '0;
      blend_ctrl_r     <= '0;
      blend_alpha_r    <= '0;
      brightness_r     <= '0;
      window_y_r       <= '0;
      engine_enabled_r <= 1'b1;
      out_valid_r      <= 1'b0;
    end else begin
      bg_control_r   <= bg_control_nxt;
      bg_hscroll_r   <= bg_hscroll_nxt;
      bg_vscroll_r   <= bg_vscroll_nxt;
      affine_r       <= affine_nxt;
      ref_point_r    <= ref_point_nxt;
      ref_reload_r   <= ref_reload_nxt;
      window_horiz_r <= window_horiz_nxt;
      window_vert_r  <= window_vert_nxt;
      win_inside_r   <= win_inside_nxt;
      win_outside_r  <= win_outside_nxt;
      mosaic_r       <= mosaic_nxt;
      blend_ctrl_r   <= blend_ctrl_nxt;
      blend_alpha_r  <= blend_alpha_nxt;
      brightness_r   <= brightness_nxt;
      window_y_r     <= window_y_nxt;
      if (cfg_valid && cfg_ready) engine_enabled_r <= cfg_data;
      if (in_fire)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // result payload: read data from the old state, flags after the beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_beat_r.read_data          <= rd_data;
      out_beat_r.window0_active     <= window_y_nxt[0];
      out_beat_r.window1_active     <= window_y_nxt[1];
      out_beat_r.ref_reload_pending <= ref_reload_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reload_sticky: assert property (@(posedge clk)
    $past(rst_n) |-> ((ref_reload_r & $past(ref_reload_r)) == $past(ref_reload_r)))
    else $error("reload flag cleared outside reset");

  a_disabled_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_beat.command == CMD_WRITE && !engine_enabled_r
    |=> $stable(ref_reload_r) && $stable(window_vert_r[0]) && $stable(mosaic_r))
    else $error("write took effect while engine disabled");

  a_read_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_beat.command == CMD_READ |=> $stable(window_y_r) && $stable(ref_reload_r))
    else $error("read beat changed flags");

  a_end_wins: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_beat.command == CMD_SCAN && in_beat.scanline[7:0] == window_vert_r[0][7:0]
    |=> !window_y_r[0])
    else $error("window 0 flag set on its end line");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no result");

endmodule

[tb/sv/tile_engine_register_file_test.sv]
// Testbench for tile_engine_register_file. Directed and random register traffic
// is checked beat by beat against a behavioral shadow of the register file.
// Depends on tef_pkg and the tile_engine_register_file RTL.
module tile_engine_register_file_test;
  import tef_pkg::*;

  // Offsets the package does not name.
  localparam logic [7:0] OFF_BGCNT_LAST  = 8'h0E;
  localparam logic [7:0] OFF_BG0HOFS     = 8'h10;
  localparam logic [7:0] OFF_BG1HOFS     = 8'h14;
  localparam logic [7:0] OFF_BG2HOFS     = 8'h18;
  localparam logic [7:0] OFF_BG3HOFS     = 8'h1C;
  localparam logic [7:0] OFF_SCROLL_LAST = 8'h1E;
  localparam logic [7:0] OFF_AFFINE0     = 8'h20;
  localparam logic [7:0] OFF_BG2X        = 8'h28;
  localparam logic [7:0] OFF_BG2Y        = 8'h2C;
  localparam logic [7:0] OFF_AFFINE1     = 8'h30;
  localparam logic [7:0] OFF_BG3X        = 8'h38;
  localparam logic [7:0] OFF_BG3Y        = 8'h3C;
  localparam logic [7:0] OFF_AFFINE_LAST = 8'h3E;
  localparam logic [7:0] OFF_UNUSED_LOW  = 8'h00;
  localparam logic [7:0] OFF_UNUSED_TOP  = 8'hFE;
  localparam logic [7:0] OFF_UNUSED_LAST = 8'hFF;

  // Encodings with no meaning: both must be harmless.
  localparam logic [1:0] CMD_NOP  = 2'd3;
  localparam logic [1:0] SIZE_BAD = 2'd3;

  localparam int IDLE_PCT        = 37;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 4;      // margin for the registered result to drain
  localparam int CYCLE_LIMIT     = 200000;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_beat_t out_beat;
  logic      cfg_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tile_engine_register_file DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file. Updated in acceptance order, so the
  // status it reports after each access is the status the block must return.
  // ---------------------------------------------------------------------------
  logic [15:0] sh_bgcnt [4];
  logic [15:0] sh_hofs [4];
  logic [15:0] sh_vofs [4];
  logic [15:0] sh_affine [8];
  logic [31:0] sh_refpt [4];
  logic [3:0]  sh_reload;        // sticky: bit0 x0, bit1 y0, bit2 x1, bit3 y1
  logic [15:0] sh_winh [2];
  logic [15:0] sh_winv [2];      // high byte start line, low byte end line
  logic [13:0] sh_winin;
  logic [13:0] sh_winout;
  logic [15:0] sh_mosaic;
  logic [13:0] sh_bldcnt;
  logic [12:0] sh_bldalpha;
  logic [4:0]  sh_bldy;
  logic [1:0]  sh_win_active;
  logic        sh_enabled;

  out_beat_t replies_due [$];    // status beats owed by the block, oldest first

  // Control shared by the stimulus and the receiver.
  logic idle_on = 1'b0;          // random gaps on both sides
  int   hold_requests = 0;       // bumped by the stimulus for each long hold-off
  int   hold_served = 0;
  int   hold_left = 0;
  int   failures = 0;
  int   cycle_count = 0;

  function automatic void shadow_reset();
    foreach (sh_bgcnt[i]) begin
      sh_bgcnt[i] = '0;
      sh_hofs[i]  = '0;
      sh_vofs[i]  = '0;
      sh_refpt[i] = '0;
    end
    foreach (sh_affine[i]) sh_affine[i] = '0;
    foreach (sh_winh[i]) begin
      sh_winh[i] = '0;
      sh_winv[i] = '0;
    end
    sh_reload     = '0;
    sh_winin      = '0;
    sh_winout     = '0;
    sh_mosaic     = '0;
    sh_bldcnt     = '0;
    sh_bldalpha   = '0;
    sh_bldy       = '0;
    sh_win_active = '0;
    sh_enabled    = 1'b1;
  endfunction

  function automatic logic [15:0] shadow_read16(logic [7:0] off);
    logic [15:0] v;
    v = '0;
    if (off >= OFF_BGCNT0 && off <= OFF_BGCNT_LAST && !off[0]) begin
      v = sh_bgcnt[off[2:1]];
    end else if (off >= OFF_BG0HOFS && off <= OFF_SCROLL_LAST && !off[0]) begin
      v = off[1] ? sh_vofs[off[3:2]] : sh_hofs[off[3:2]];
    end else begin
      case (off)
        OFF_WIN0V:    v = sh_winv[0];
        OFF_WIN1V:    v = sh_winv[1];
        OFF_WININ:    v = {2'b00, sh_winin};
        OFF_WINOUT:   v = {2'b00, sh_winout};
        OFF_BLDCNT:   v = {2'b00, sh_bldcnt};
        OFF_BLDALPHA: v = {3'b000, sh_bldalpha};
        default:      v = '0;      // write-only or undecoded
      endcase
    end
    return v;
  endfunction

  // Only a few offsets decode as word reads; everything else reads as zero.
  function automatic logic [31:0] shadow_read32(logic [7:0] off);
    case (off)
      OFF_BGCNT0, OFF_BGCNT2, OFF_BG0HOFS, OFF_BG1HOFS, OFF_BG2HOFS, OFF_BG3HOFS,
      OFF_WININ:
        return {shadow_read16(off + 8'd2), shadow_read16(off)};
      default:
        return '0;
    endcase
  endfunction

  function automatic void shadow_write16(logic [7:0] off, logic [15:0] v);
    logic       bank;
    logic [1:0] pt;
    if (off >= OFF_BGCNT0 && off <= OFF_BGCNT_LAST && !off[0]) begin
      sh_bgcnt[off[2:1]] = v;
    end else if (off >= OFF_BG0HOFS && off <= OFF_SCROLL_LAST && !off[0]) begin
      if (off[1]) sh_vofs[off[3:2]] = v;
      else sh_hofs[off[3:2]] = v;
    end else if (off >= OFF_AFFINE0 && off <= OFF_AFFINE_LAST && !off[0]) begin
      bank = (off >= OFF_AFFINE1);
      if (!off[3]) begin
        sh_affine[{bank, off[2:1]}] = v;        // pa pb pc pd of the bank
      end else begin
        pt = {bank, off[2]};                    // reference point x or y
        if (off[1]) sh_refpt[pt][31:16] = v;
        else sh_refpt[pt][15:0] = v;
        sh_reload[pt] = 1'b1;
      end
    end else begin
      case (off)
        OFF_WIN0H:    sh_winh[0] = v;
        OFF_WIN1H:    sh_winh[1] = v;
        OFF_WIN0V:    sh_winv[0] = v;
        OFF_WIN1V:    sh_winv[1] = v;
        OFF_WININ:    sh_winin = v[13:0] & WIN_SEL_MASK;
        OFF_WINOUT:   sh_winout = v[13:0] & WIN_SEL_MASK;
        OFF_MOSAIC:   sh_mosaic = v;
        OFF_BLDCNT:   sh_bldcnt = v[13:0] & BLEND_CTRL_MASK;
        OFF_BLDALPHA: sh_bldalpha = v[12:0] & BLEND_ALPHA_MASK;
        OFF_BLDY:     sh_bldy = v[4:0];
        default:      ;
      endcase
    end
  endfunction

  function automatic logic [15:0] merge_byte(logic [15:0] old, logic odd, logic [7:0] b);
    return odd ? {b, old[7:0]} : {old[15:8], b};
  endfunction

  // Byte writes reach only the window and mosaic registers; each window keeps
  // its own merge.
  function automatic void shadow_write8(logic [7:0] off, logic [7:0] b);
    case (off)
      OFF_WIN0H, OFF_WIN0H + 8'd1:   sh_winh[0] = merge_byte(sh_winh[0], off[0], b);
      OFF_WIN1H, OFF_WIN1H + 8'd1:   sh_winh[1] = merge_byte(sh_winh[1], off[0], b);
      OFF_WIN0V, OFF_WIN0V + 8'd1:   sh_winv[0] = merge_byte(sh_winv[0], off[0], b);
      OFF_WIN1V, OFF_WIN1V + 8'd1:   sh_winv[1] = merge_byte(sh_winv[1], off[0], b);
      OFF_MOSAIC, OFF_MOSAIC + 8'd1: sh_mosaic = merge_byte(sh_mosaic, off[0], b);
      default: ;
    endcase
  endfunction

  // Word writes without their own decode become two halfword writes; the
  // upper half wraps around the 8-bit offset space.
  function automatic void shadow_write32(logic [7:0] off, logic [31:0] v);
    case (off)
      OFF_BG2X: begin
        sh_refpt[0] = v;
        sh_reload[0] = 1'b1;
      end
      OFF_BG2Y: begin
        sh_refpt[1] = v;
        sh_reload[1] = 1'b1;
      end
      OFF_BG3X: begin
        sh_refpt[2] = v;
        sh_reload[2] = 1'b1;
      end
      OFF_BG3Y: begin
        sh_refpt[3] = v;
        sh_reload[3] = 1'b1;
      end
      OFF_MOSAIC: sh_mosaic = v[15:0];
      OFF_BLDY:   sh_bldy = v[4:0];
      default: begin
        shadow_write16(off, v[15:0]);
        shadow_write16(off + 8'd2, v[31:16]);
      end
    endcase
  endfunction

  // Start line sets the flag, end line clears it; end is applied last so it wins.
  function automatic void shadow_scanline(logic [8:0] line);
    for (int w = 0; w < 2; w++) begin
      if (line[7:0] == sh_winv[w][15:8]) sh_win_active[w] = 1'b1;
      if (line[7:0] == sh_winv[w][7:0]) sh_win_active[w] = 1'b0;
    end
  endfunction

  function automatic out_beat_t apply_access(in_beat_t b);
    out_beat_t r;
    r = '0;
    case (b.command)
      CMD_READ: begin
        if (b.access_size == SIZE_HALF) r.read_data = {16'h0000, shadow_read16(b.offset)};
        else if (b.access_size == SIZE_WORD) r.read_data = shadow_read32(b.offset);
      end
      CMD_WRITE: begin
        if (sh_enabled) begin
          case (b.access_size)
            SIZE_BYTE: shadow_write8(b.offset, b.write_data[7:0]);
            SIZE_HALF: shadow_write16(b.offset, b.write_data[15:0]);
            SIZE_WORD: shadow_write32(b.offset, b.write_data);
            default:   ;
          endcase
        end
      end
      CMD_SCAN: shadow_scanline(b.scanline);
      default:  ;
    endcase
    r.window0_active     = sh_win_active[0];
    r.window1_active     = sh_win_active[1];
    r.ref_reload_pending = sh_reload;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat helpers
  // ---------------------------------------------------------------------------
  function automatic in_beat_t make_access(logic [1:0] cmd, logic [1:0] size,
                                           logic [7:0] off, logic [31:0] data,
                                           logic [8:0] line);
    in_beat_t b;
    b.command     = cmd;
    b.access_size = size;
    b.offset      = off;
    b.write_data  = data;
    b.scanline    = line;
    return b;
  endfunction

  // Mostly decoded offsets with sensible alignment; scanline events usually
  // land on a window's current start or end line so the flags really move.
  function automatic in_beat_t random_access();
    in_beat_t    b;
    int unsigned pick;
    logic        w;
    pick = $urandom_range(99);
    b.command = (pick < 4) ? CMD_NOP : (pick < 40) ? CMD_READ :
                (pick < 78) ? CMD_WRITE : CMD_SCAN;
    pick = $urandom_range(99);
    b.access_size = (pick < 5) ? SIZE_BAD : (pick < 30) ? SIZE_BYTE :
                    (pick < 65) ? SIZE_HALF : SIZE_WORD;
    if ($urandom_range(99) < 15) begin
      b.offset = 8'($urandom_range(255));
    end else begin
      b.offset = 8'($urandom_range(OFF_BGCNT0, OFF_BLDY + 8'd1));
      if (b.access_size == SIZE_WORD && $urandom_range(3) != 0) b.offset[1:0] = 2'b00;
      else if (b.access_size != SIZE_BYTE && $urandom_range(7) != 0) b.offset[0] = 1'b0;
    end
    pick = $urandom_range(99);
    if (pick < 8) b.write_data = '1;
    else if (pick < 12) b.write_data = '0;
    else b.write_data = $urandom();
    b.scanline = 9'($urandom_range(511));
    if (b.command == CMD_SCAN && $urandom_range(99) < 70) begin
      w = 1'($urandom_range(1));
      b.scanline[7:0] = $urandom_range(1) ? sh_winv[w][15:8] : sh_winv[w][7:0];
    end
    return b;
  endfunction

  // Offer one beat from the falling edge and hold it until the block takes it.
  // Valid is left high after acceptance: the next call either replaces the
  // payload or drops valid, but never both in the same step.
  task automatic send_access(input in_beat_t b);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies_due.push_back(apply_access(b));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Engine enable is only changed with the block drained.
  task automatic set_engine_enabled(input logic en);
    idle_input();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sh_enabled = en;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every returned beat against the oldest owed status
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_reply
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result beat, read_data %h", out_beat.read_data);
        failures++;
      end else begin
        want = replies_due.pop_front();
        if (out_beat.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_beat.read_data);
          failures++;
        end
        if (out_beat.window0_active !== want.window0_active) begin
          $error("window0_active: expected %b, got %b",
                 want.window0_active, out_beat.window0_active);
          failures++;
        end
        if (out_beat.window1_active !== want.window1_active) begin
          $error("window1_active: expected %b, got %b",
                 want.window1_active, out_beat.window1_active);
          failures++;
        end
        if (out_beat.ref_reload_pending !== want.ref_reload_pending) begin
          $error("ref_reload_pending: expected %h, got %h",
                 want.ref_reload_pending, out_beat.ref_reload_pending);
          failures++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tile_engine_register_file test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    send_access(make_access(CMD_READ, SIZE_WORD, OFF_BGCNT0, '0, '0));
    send_access(make_access(CMD_READ, SIZE_HALF, OFF_WIN0V, '0, '0));
    idle_input();
  endtask

  // Field masks, byte read returning zero, word splits, write-only registers.
  task automatic test_masks_and_splits();
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_BGCNT0, 32'hFFFF_0000, '0));
    send_access(make_access(CMD_READ, SIZE_WORD, OFF_BGCNT0, '0, '0));
    send_access(make_access(CMD_READ, SIZE_BYTE, OFF_BGCNT0 + 8'd2, '0, '0));
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_WININ, '1, '0));
    send_access(make_access(CMD_READ, SIZE_WORD, OFF_WININ, '0, '0));
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_BLDCNT, '1, '0));
    send_access(make_access(CMD_READ, SIZE_HALF, OFF_BLDALPHA, '0, '0));
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_MOSAIC, 32'hFFFF_1234, '0));
    send_access(make_access(CMD_READ, SIZE_HALF, OFF_MOSAIC, '0, '0));
    idle_input();
  endtask

  // Every write path into a reference point raises its sticky reload flag.
  task automatic test_reference_reload();
    send_access(make_access(CMD_WRITE, SIZE_HALF, OFF_BG2X + 8'd2, 32'h0000_FFFF, '0));
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_BG3Y, '0, '0));
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_AFFINE1, '1, '0));
    send_access(make_access(CMD_WRITE, SIZE_HALF, OFF_BG3X, 32'h0000_8000, '0));
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_BG2Y, 32'h8000_0001, '0));
    idle_input();
  endtask

  // Window 1 byte merges, line count bit 8 ignored, end beats start.
  task automatic test_window_flags();
    send_access(make_access(CMD_WRITE, SIZE_BYTE, OFF_WIN1V, 32'hFFFF_FF20, '0));
    send_access(make_access(CMD_WRITE, SIZE_BYTE, OFF_WIN1V + 8'd1, 32'h0000_0010, '0));
    send_access(make_access(CMD_READ, SIZE_HALF, OFF_WIN1V, '0, '0));
    send_access(make_access(CMD_SCAN, SIZE_BYTE, '0, '0, 9'h110));
    send_access(make_access(CMD_SCAN, SIZE_BYTE, '0, '0, 9'h020));
    send_access(make_access(CMD_WRITE, SIZE_HALF, OFF_WIN0V, 32'h0000_3030, '0));
    send_access(make_access(CMD_SCAN, SIZE_WORD, '0, '0, 9'h030));
    idle_input();
  endtask

  // Unused encodings, undecoded and odd offsets, the wrapping split.
  task automatic test_odd_accesses();
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_UNUSED_TOP, '1, '0));
    send_access(make_access(CMD_WRITE, SIZE_BAD, OFF_BGCNT0, '1, '0));
    send_access(make_access(CMD_READ, SIZE_BAD, OFF_BGCNT0 + 8'd2, '0, '0));
    send_access(make_access(CMD_NOP, SIZE_BAD, OFF_UNUSED_LAST, '1, '1));
    send_access(make_access(CMD_WRITE, SIZE_HALF, OFF_BGCNT0 + 8'd1, '1, '0));
    send_access(make_access(CMD_READ, SIZE_WORD, OFF_UNUSED_LAST, '0, '0));
    send_access(make_access(CMD_WRITE, SIZE_WORD, OFF_BLDY, '1, '0));
    send_access(make_access(CMD_WRITE, SIZE_BYTE, OFF_UNUSED_LOW, '1, '0));
    idle_input();
  endtask

  // With the engine off, writes drop but reads and scanlines still run.
  task automatic test_engine_disable();
    set_engine_enabled(1'b0);
    send_access(make_access(CMD_WRITE, SIZE_HALF, OFF_BGCNT0, 32'h0000_1234, '0));
    send_access(make_access(CMD_WRITE, SIZE_BYTE, OFF_WIN0V + 8'd1, 32'h0000_0055, '0));
    send_access(make_access(CMD_SCAN, SIZE_BYTE, '0, '0, 9'h055));
    send_access(make_access(CMD_READ, SIZE_WORD, OFF_BGCNT0, '0, '0));
    set_engine_enabled(1'b1);
  endtask

  // The receiver stops for a long stretch while beats keep coming: the output
  // register fills and in_ready must fall without losing anything.
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 20; i++) send_access(random_access());
    idle_input();
  endtask

  task automatic test_random_traffic(input int count, input logic gaps);
    idle_on = gaps;
    for (int i = 0; i < count; i++) send_access(random_access());
    idle_input();
  endtask

  initial begin
    shadow_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_masks_and_splits();
    test_reference_reload();
    test_window_flags();
    test_odd_accesses();
    test_engine_disable();
    test_output_backpressure();
    test_random_traffic(300, 1'b0);     // back to back, no stalls anywhere
    test_random_traffic(400, 1'b1);
    set_engine_enabled(1'b0);
    test_random_traffic(150, 1'b1);
    set_engine_enabled(1'b1);
    test_random_traffic(400, 1'b1);

    // drain, then give any stray beat a chance to show up
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tile_engine_register_file test passed");
    end else begin
      $display("tile_engine_register_file test failed");
    end
    $finish;
  end

endmodule
